[sv/dek_pkg.sv]
package dek_pkg;

	// Longest long-form length field accepted, in bytes
	localparam int unsigned DEK_MAX_LEN_BYTES = 4;
	// Default depth of the result queue (at least 2)
	localparam int unsigned DEK_OUT_DEPTH = 4;
	// Elements of tbsCertificate skipped after the optional version
	localparam int unsigned DEK_TBS_SKIP_COUNT = 5;

	// DER tags and length-octet fields
	localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
	localparam logic [7:0] TAG_VERSION    = 8'hA0;
	localparam logic [7:0] TAG_BIT_STRING = 8'h03;
	localparam logic [7:0] LEN_LONG_FORM  = 8'h80;
	localparam logic [7:0] UNUSED_BITS_OK = 8'h00;

	// Result kinds
	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_FIRST_TAG,
		PH_LEN0,
		PH_LENN,
		PH_SKIP_VAL,
		PH_UNUSED,
		PH_KEY,
		PH_DONE
	} dek_phase_t;

	typedef enum logic [2:0] {
		EL_CERT,
		EL_TBS,
		EL_TBS_SKIP,
		EL_SPKI,
		EL_ALG,
		EL_BIT
	} dek_elem_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  key_byte;
		logic        success;
		logic [31:0] key_length;
		logic        run_last;
	} dek_result_t;

	// Up to two results per input byte; v1 is only set together with v0
	typedef struct packed {
		logic        v0;
		logic        v1;
		dek_result_t r0;
		dek_result_t r1;
	} dek_push_t;

endpackage

[sv/dek_in_if.sv]
interface dek_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] cert_byte;
	logic       cert_end;

	modport source (output valid, output cert_byte, output cert_end, input ready);
	modport sink (input valid, input cert_byte, input cert_end, output ready);
endinterface

[sv/dek_out_if.sv]
interface dek_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  key_byte;
	logic        success;
	logic [31:0] key_length;
	logic        run_last;

	modport source (output valid, output result_kind, output key_byte, output success,
		output key_length, output run_last, input ready);
	modport sink (input valid, input result_kind, input key_byte, input success,
		input key_length, input run_last, output ready);
endinterface

[sv/dek_parser.sv]
module dek_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_xfer,
	input  logic [7:0]         cert_byte,
	input  logic               cert_end,
	output dek_pkg::dek_push_t push
);
	import dek_pkg::*;

	dek_phase_t  phase_q, phase_n;
	dek_elem_t   elem_q, elem_n;
	logic [31:0] len_acc_q, len_acc_n;
	logic [2:0]  len_left_q, len_left_n;
	logic [2:0]  skip_cnt_q, skip_cnt_n;
	logic [31:0] cert_rem_q, cert_rem_n;
	logic [31:0] tbs_rem_q, tbs_rem_n;
	logic [31:0] spki_rem_q, spki_rem_n;
	logic [31:0] elem_rem_q, elem_rem_n;
	logic [31:0] key_cnt_q, key_cnt_n;
	logic        failed_q, failed_n;

	logic [1:0]  depth;
	logic        take_ok;
	logic        emit;
	logic        hdr_fire;
	logic [31:0] hdr_len;
	logic        hdr_fits;
	logic        elem_fin;
	logic [6:0]  n_len_bytes;
	logic        status_ok;
	dek_result_t key_res, status_res;

	// Nesting depth of the element whose header or value is being parsed
	function automatic logic [1:0] elem_depth(input dek_elem_t e);
		logic [1:0] d;
		unique case (e)
			EL_CERT:              d = 2'd0;
			EL_TBS:               d = 2'd1;
			EL_TBS_SKIP, EL_SPKI: d = 2'd2;
			default:              d = 2'd3;
		endcase
		return d;
	endfunction

	assign depth = elem_depth(elem_q);
	// Every enclosing container must still have room for this byte
	assign take_ok = !((depth >= 2'd1 && cert_rem_q == '0) ||
		(depth >= 2'd2 && tbs_rem_q == '0) ||
		(depth == 2'd3 && spki_rem_q == '0));
	assign n_len_bytes = cert_byte[6:0];

	// Next state for one byte
	always_comb begin
		phase_n    = phase_q;
		elem_n     = elem_q;
		len_acc_n  = len_acc_q;
		len_left_n = len_left_q;
		skip_cnt_n = skip_cnt_q;
		cert_rem_n = cert_rem_q;
		tbs_rem_n  = tbs_rem_q;
		spki_rem_n = spki_rem_q;
		elem_rem_n = elem_rem_q;
		key_cnt_n  = key_cnt_q;
		failed_n   = failed_q;
		emit       = 1'b0;
		hdr_fire   = 1'b0;
		hdr_len    = {24'd0, cert_byte};
		hdr_fits   = 1'b1;
		elem_fin   = 1'b0;

		if (!failed_q) begin
			if (phase_q == PH_DONE) begin
				// trailing bytes only run down the certificate
				if (cert_rem_q != '0)
					cert_rem_n = cert_rem_q - 32'd1;
			end else if (!take_ok) begin
				failed_n = 1'b1;
			end else begin
				if (depth >= 2'd1)
					cert_rem_n = cert_rem_q - 32'd1;
				if (depth >= 2'd2)
					tbs_rem_n = tbs_rem_q - 32'd1;
				if (depth == 2'd3)
					spki_rem_n = spki_rem_q - 32'd1;

				unique case (phase_q)
					PH_FIRST_TAG: begin
						if (cert_byte != TAG_VERSION)
							skip_cnt_n = skip_cnt_q + 3'd1;
						phase_n = PH_LEN0;
					end
					PH_TAG: begin
						phase_n = PH_LEN0;
						if (elem_q == EL_TBS_SKIP)
							skip_cnt_n = skip_cnt_q + 3'd1;
						else if (elem_q == EL_BIT) begin
							if (cert_byte != TAG_BIT_STRING)
								failed_n = 1'b1;
						end else if (elem_q != EL_ALG) begin
							if (cert_byte != TAG_SEQUENCE)
								failed_n = 1'b1;
						end
					end
					PH_LEN0: begin
						if (cert_byte < LEN_LONG_FORM) begin
							hdr_fire = 1'b1;
						end else if (n_len_bytes == '0 ||
							n_len_bytes > 7'(DEK_MAX_LEN_BYTES)) begin
							failed_n = 1'b1;
						end else begin
							len_left_n = n_len_bytes[2:0];
							len_acc_n  = '0;
							phase_n    = PH_LENN;
						end
					end
					PH_LENN: begin
						len_acc_n  = {len_acc_q[23:0], cert_byte};
						len_left_n = len_left_q - 3'd1;
						hdr_len    = {len_acc_q[23:0], cert_byte};
						if (len_left_n == '0)
							hdr_fire = 1'b1;
					end
					PH_SKIP_VAL: begin
						elem_rem_n = elem_rem_q - 32'd1;
						if (elem_rem_n == '0)
							elem_fin = 1'b1;
					end
					PH_UNUSED: begin
						if (cert_byte != UNUSED_BITS_OK)
							failed_n = 1'b1;
						else begin
							elem_rem_n = elem_rem_q - 32'd1;
							phase_n    = PH_KEY;
						end
					end
					PH_KEY: begin
						emit       = 1'b1;
						key_cnt_n  = key_cnt_q + 32'd1;
						elem_rem_n = elem_rem_q - 32'd1;
						if (elem_rem_n == '0)
							phase_n = PH_DONE;
					end
					PH_DONE: ;
				endcase

				// Declared length against room left in the immediate container
				unique case (depth)
					2'd0:    hdr_fits = 1'b1;
					2'd1:    hdr_fits = hdr_len <= cert_rem_n;
					2'd2:    hdr_fits = hdr_len <= tbs_rem_n;
					default: hdr_fits = hdr_len <= spki_rem_n;
				endcase

				// Header complete: open the element
				if (hdr_fire) begin
					if (!hdr_fits)
						failed_n = 1'b1;
					else begin
						unique case (elem_q)
							EL_CERT: begin
								cert_rem_n = hdr_len;
								elem_n     = EL_TBS;
								phase_n    = PH_TAG;
							end
							EL_TBS: begin
								tbs_rem_n = hdr_len;
								elem_n    = EL_TBS_SKIP;
								phase_n   = PH_FIRST_TAG;
							end
							EL_SPKI: begin
								spki_rem_n = hdr_len;
								elem_n     = EL_ALG;
								phase_n    = PH_TAG;
							end
							EL_BIT: begin
								if (hdr_len < 32'd2)
									failed_n = 1'b1;
								else begin
									elem_rem_n = hdr_len;
									phase_n    = PH_UNUSED;
								end
							end
							default: begin
								elem_rem_n = hdr_len;
								if (hdr_len == '0)
									elem_fin = 1'b1;
								else
									phase_n = PH_SKIP_VAL;
							end
						endcase
					end
				end

				// Skipped element done: pick the next one
				if (elem_fin) begin
					phase_n = PH_TAG;
					if (elem_q == EL_TBS_SKIP)
						elem_n = (skip_cnt_n >= 3'(DEK_TBS_SKIP_COUNT)) ? EL_SPKI : EL_TBS_SKIP;
					else
						elem_n = EL_BIT;
				end
			end
		end
	end

	// Results for the byte
	always_comb begin
		status_ok = !failed_n && phase_n == PH_DONE && cert_rem_n == '0;

		key_res.result_kind = KIND_KEY;
		key_res.key_byte    = cert_byte;
		key_res.success     = 1'b0;
		key_res.key_length  = '0;
		key_res.run_last    = 1'b0;

		status_res.result_kind = KIND_STATUS;
		status_res.key_byte    = '0;
		status_res.success     = status_ok;
		status_res.key_length  = key_cnt_n;
		status_res.run_last    = 1'b1;

		push.v0 = in_xfer && (emit || cert_end);
		push.v1 = in_xfer && emit && cert_end;
		push.r0 = emit ? key_res : status_res;
		push.r1 = status_res;
	end

	// State update; the last byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			elem_q     <= EL_CERT;
			len_acc_q  <= '0;
			len_left_q <= '0;
			skip_cnt_q <= '0;
			cert_rem_q <= '0;
			tbs_rem_q  <= '0;
			spki_rem_q <= '0;
			elem_rem_q <= '0;
			key_cnt_q  <= '0;
			failed_q   <= 1'b0;
		end else if (in_xfer) begin
			if (cert_end) begin
				phase_q    <= PH_TAG;
				elem_q     <= EL_CERT;
				len_acc_q  <= '0;
				len_left_q <= '0;
				skip_cnt_q <= '0;
				cert_rem_q <= '0;
				tbs_rem_q  <= '0;
				spki_rem_q <= '0;
				elem_rem_q <= '0;
				key_cnt_q  <= '0;
				failed_q   <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				elem_q     <= elem_n;
				len_acc_q  <= len_acc_n;
				len_left_q <= len_left_n;
				skip_cnt_q <= skip_cnt_n;
				cert_rem_q <= cert_rem_n;
				tbs_rem_q  <= tbs_rem_n;
				spki_rem_q <= spki_rem_n;
				elem_rem_q <= elem_rem_n;
				key_cnt_q  <= key_cnt_n;
				failed_q   <= failed_n;
			end
		end
	end

endmodule

[sv/dek_out_queue.sv]
module dek_out_queue #(
	parameter int unsigned DEPTH = dek_pkg::DEK_OUT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dek_pkg::dek_push_t push,
	output logic               can_take,
	dek_out_if.source          result
);
	import dek_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dek_result_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	dek_result_t      head;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1 = ptr_inc(wr_ptr_q);
	assign pop      = result.valid && result.ready;
	// Room for the worst case of two results from one byte
	assign can_take = count_q <= CNT_W'(DEPTH - 2);

	// Head of queue drives the output channel
	assign head               = mem_q[rd_ptr_q];
	assign result.valid       = count_q != '0;
	assign result.result_kind = head.result_kind;
	assign result.key_byte    = head.key_byte;
	assign result.success     = head.success;
	assign result.key_length  = head.key_length;
	assign result.run_last    = head.run_last;

	// Storage
	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.v1)
			mem_q[wr_ptr_1] <= push.r1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.v1)
				wr_ptr_q <= ptr_inc(wr_ptr_1);
			else if (push.v0)
				wr_ptr_q <= wr_ptr_1;
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
		end
	end

endmodule

[sv/der_cert_ec_key_extractor.sv]
// Streams a DER X.509 certificate in, one byte per transfer on cert, and hands out
// the subject's EC public key on result: one key-byte item (result_kind 0) per key
// byte as it passes, then on the byte marked cert_end one status item (result_kind 1,
// run_last 1) with success and the number of key bytes sent. Key bytes are
// provisional until the status item says success. Each byte is parsed as it is
// transferred and its results are registered in the result queue, whose head drives
// result. A byte is taken in every cycle in which the result queue (OUT_DEPTH
// entries) holds at most OUT_DEPTH-2 results, so both results of one byte always
// fit. The queue drains one result per cycle while the sink is ready; with OUT_DEPTH
// of at least 4 and a sink that is always ready it never holds more than two results,
// so bytes flow back to back with no stall, the byte that carries both the last key
// byte and cert_end included. At such depths only a stalled sink holds the input off.
module der_cert_ec_key_extractor #(
	parameter int unsigned OUT_DEPTH = dek_pkg::DEK_OUT_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	dek_in_if.sink    cert,
	dek_out_if.source result
);
	import dek_pkg::*;

	logic      in_xfer;
	logic      can_take;
	dek_push_t push;

	// Input handshake
	assign cert.ready = can_take;
	assign in_xfer    = cert.valid && can_take;

	dek_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_xfer   (in_xfer),
		.cert_byte (cert.cert_byte),
		.cert_end  (cert.cert_end),
		.push      (push)
	);

	dek_out_queue #(
		.DEPTH (OUT_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.can_take (can_take),
		.result   (result)
	);

endmodule
